// ===== src/bma_pkg.sv =====
// Shared constants for the binary moment accumulator: register map, field widths and resets.
package bma_pkg;

    // Configuration register widths.
    localparam int IMG_W_BITS = 12;
    localparam int ROW_START_BITS = 11;
    localparam int ROW_STOP_BITS = 12;
    localparam int COL_BITS = 12;

    // Stream field widths.
    localparam int PIXEL_BITS = 8;
    localparam int SUM_BITS = 32;
    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 3 * SUM_BITS;

    // APB port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [2:0] REG_ROW_START = 3'd1;
    localparam logic [2:0] REG_ROW_STOP = 3'd2;
    localparam logic [2:0] REG_COL_START = 3'd3;
    localparam logic [2:0] REG_COL_STOP = 3'd4;

    // Register reset values.
    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST = 12'd640;
    localparam logic [ROW_START_BITS-1:0] ROW_START_RST = 11'd0;
    localparam logic [ROW_STOP_BITS-1:0] ROW_STOP_RST = 12'd2048;
    localparam logic [COL_BITS-1:0] COL_START_RST = 12'd0;
    localparam logic [COL_BITS-1:0] COL_STOP_RST = 12'd2048;

endpackage

// ===== src/binary_moment_accumulator_unit.sv =====
// Top level of the binary moment accumulator: position tracking, window test and moment sums.
//
// The block takes one 8-bit pixel per clock in raster order and tracks column and row itself;
// a pixel with bit 7 set is counted when its row lies in [row_start, row_stop) and its
// BLOCK_PIXELS-wide column block overlaps [col_start, col_stop). On the word marked with
// s_tlast the pixel is accumulated and one result word carries the pixel count, the column sum
// and the row sum (each modulo 2^32); the sums and position then restart from zero. Each pixel
// passes two register stages (window test, then accumulate); a result word becomes valid when
// its frame-end word leaves the window test register and is registered as the result. The intake
// stalls only while a finished result still waits on m_tready and the next frame end already
// waits in the window test register.
module binary_moment_accumulator_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int BLOCK_PIXELS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bma_pkg::APB_AW-1:0]        paddr,
    input  logic [bma_pkg::APB_DW-1:0]        pwdata,
    output logic [bma_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    // Pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bma_pkg::S_TDATA_BITS-1:0]  s_tdata,   // [7:0] pixel
    input  logic                              s_tlast,   // frame_end
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bma_pkg::M_TDATA_BITS-1:0]  m_tdata    // [31:0] pixel_count,
                                                         // [63:32] sum_x, [95:64] sum_y
);
    import bma_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int OFF_W = (BLOCK_PIXELS > 1) ? $clog2(BLOCK_PIXELS) : 1;
    // Compare widths with headroom for base + BLOCK_PIXELS and col + 1.
    localparam int CCMP_W = ((COL_W > COL_BITS) ? COL_W : COL_BITS) + 2;
    localparam int RCMP_W = ((ROW_W > ROW_STOP_BITS) ? ROW_W : ROW_STOP_BITS) + 1;
    localparam logic [CCMP_W-1:0] BLOCK_C = CCMP_W'(BLOCK_PIXELS);
    localparam logic [CCMP_W-1:0] MAX_W_C = CCMP_W'(MAX_WIDTH);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_PIXELS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

    // Configuration registers.
    logic [IMG_W_BITS-1:0]     image_width_reg;
    logic [ROW_START_BITS-1:0] row_start_reg;
    logic [ROW_STOP_BITS-1:0]  row_stop_reg;
    logic [COL_BITS-1:0]       col_start_reg;
    logic [COL_BITS-1:0]       col_stop_reg;

    // Position tracking; the block base and offset stand in for col / BLOCK_PIXELS.
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] base_reg, base_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Window test stage.
    logic             v1_reg;
    logic             hit1_reg;
    logic             last1_reg;
    logic [COL_W-1:0] col1_reg;
    logic [ROW_W-1:0] row1_reg;

    // Accumulators and result register.
    logic [SUM_BITS-1:0] cnt_acc_reg, x_acc_reg, y_acc_reg;
    logic [SUM_BITS-1:0] cnt_sum, x_sum, y_sum;
    logic                out_v_reg;
    logic [SUM_BITS-1:0] out_cnt_reg, out_x_reg, out_y_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        stall;
    logic        take_in;
    logic        step1;
    logic        hit;
    logic        row_ok;
    logic        blk_ok;
    logic [CCMP_W-1:0] col_inc;
    logic [CCMP_W-1:0] base_ext;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= IMAGE_WIDTH_RST;
            row_start_reg   <= ROW_START_RST;
            row_stop_reg    <= ROW_STOP_RST;
            col_start_reg   <= COL_START_RST;
            col_stop_reg    <= COL_STOP_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH: image_width_reg <= pwdata[IMG_W_BITS-1:0];
                REG_ROW_START:   row_start_reg   <= pwdata[ROW_START_BITS-1:0];
                REG_ROW_STOP:    row_stop_reg    <= pwdata[ROW_STOP_BITS-1:0];
                REG_COL_START:   col_start_reg   <= pwdata[COL_BITS-1:0];
                REG_COL_STOP:    col_stop_reg    <= pwdata[COL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_IMAGE_WIDTH: prdata = APB_DW'(image_width_reg);
            REG_ROW_START:   prdata = APB_DW'(row_start_reg);
            REG_ROW_STOP:    prdata = APB_DW'(row_stop_reg);
            REG_COL_START:   prdata = APB_DW'(col_start_reg);
            REG_COL_STOP:    prdata = APB_DW'(col_stop_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // Only a frame end that would overwrite an unread result holds the pipe.
    assign stall    = v1_reg && last1_reg && out_v_reg && !m_tready;
    assign s_tready = !stall;
    assign take_in  = s_tvalid && s_tready;
    assign step1    = v1_reg && !stall;

    // ---------------- window test and position ----------------
    assign base_ext = CCMP_W'(base_reg);
    assign row_ok = (RCMP_W'(row_reg) >= RCMP_W'(row_start_reg))
                 && (RCMP_W'(row_reg) <  RCMP_W'(row_stop_reg));
    assign blk_ok = !((base_ext + BLOCK_C) <= CCMP_W'(col_start_reg))
                 && !(CCMP_W'(col_stop_reg) <= base_ext);
    assign hit    = s_tdata[PIXEL_BITS-1] && row_ok && blk_ok;
    assign col_inc = CCMP_W'(col_reg) + CCMP_W'(1);

    always_comb begin
        col_next  = col_reg;
        base_next = base_reg;
        off_next  = off_reg;
        row_next  = row_reg;
        if (take_in) begin
            if (s_tlast) begin
                col_next  = '0;
                base_next = '0;
                off_next  = '0;
                row_next  = '0;
            end else if (col_inc >= CCMP_W'(image_width_reg) || col_inc >= MAX_W_C) begin
                col_next  = '0;
                base_next = '0;
                off_next  = '0;
                row_next  = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_inc[COL_W-1:0];
                if (off_reg == OFF_LAST) begin
                    off_next  = '0;
                    base_next = col_inc[COL_W-1:0];
                end else begin
                    off_next = off_reg + OFF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            base_reg <= '0;
            off_reg  <= '0;
            row_reg  <= '0;
            v1_reg   <= 1'b0;
        end else begin
            col_reg  <= col_next;
            base_reg <= base_next;
            off_reg  <= off_next;
            row_reg  <= row_next;
            if (!stall) begin
                v1_reg <= take_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            hit1_reg  <= hit;
            last1_reg <= s_tlast;
            col1_reg  <= col_reg;
            row1_reg  <= row_reg;
        end
    end

    // ---------------- accumulate ----------------
    assign cnt_sum = cnt_acc_reg + SUM_BITS'(hit1_reg);
    assign x_sum   = x_acc_reg + (hit1_reg ? SUM_BITS'(col1_reg) : '0);
    assign y_sum   = y_acc_reg + (hit1_reg ? SUM_BITS'(row1_reg) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_acc_reg <= '0;
            x_acc_reg   <= '0;
            y_acc_reg   <= '0;
            out_v_reg   <= 1'b0;
        end else begin
            if (out_v_reg && m_tready) begin
                out_v_reg <= 1'b0;
            end
            if (step1) begin
                if (last1_reg) begin
                    cnt_acc_reg <= '0;
                    x_acc_reg   <= '0;
                    y_acc_reg   <= '0;
                    out_v_reg   <= 1'b1;
                end else begin
                    cnt_acc_reg <= cnt_sum;
                    x_acc_reg   <= x_sum;
                    y_acc_reg   <= y_sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step1 && last1_reg) begin
            out_cnt_reg <= cnt_sum;
            out_x_reg   <= x_sum;
            out_y_reg   <= y_sum;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_y_reg, out_x_reg, out_cnt_reg};

endmodule
